// File: rtl/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package sitda_pkg;

    // input word and decimal digit sizes
    localparam int C_VALUE_W    = 32;
    localparam int C_NUM_DIGITS = 10;
    localparam int C_DIGIT_W    = 4;
    localparam int C_BCD_W      = C_NUM_DIGITS * C_DIGIT_W;
    localparam int C_CHAR_W     = 8;

    // ascii codes
    localparam logic [C_CHAR_W-1:0] C_CHAR_ZERO  = 8'h30;
    localparam logic [C_CHAR_W-1:0] C_CHAR_MINUS = 8'h2D;

    // converted number handed from the bcd engine to the emitter
    typedef struct packed {
        logic               neg;
        logic [C_BCD_W-1:0] bcd;
    } t_bcd_result;

endpackage

// File: rtl/sitda_bcd.sv
// ----------------------------------------------------------------------------
// sitda_bcd
// Bit-serial binary to bcd converter (shift and add-3), one input bit a cycle.
// ----------------------------------------------------------------------------
module sitda_bcd
    import sitda_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [C_VALUE_W-1:0] i_value,
    output logic                        o_busy,
    output logic                        o_done,
    output t_bcd_result                 o_result
);

    localparam int C_CNT_W = $clog2(C_VALUE_W);

    logic                 r_busy;
    logic                 r_done;
    logic [C_CNT_W-1:0]   r_cnt;
    logic [C_VALUE_W-1:0] r_bin;
    logic [C_BCD_W-1:0]   r_bcd;
    logic                 r_neg;
    logic [C_BCD_W-1:0]   w_adj;
    logic [C_VALUE_W-1:0] w_mag;

    // magnitude in unsigned arithmetic, so the most negative value is exact
    assign w_mag = i_value[C_VALUE_W-1] ? (~i_value + 1'b1) : i_value;

    // add 3 to every digit of 5 or more ahead of the shift
    always_comb begin
        logic [C_DIGIT_W-1:0] v_dig;
        w_adj = r_bcd;
        for (int d = 0; d < C_NUM_DIGITS; d++) begin
            v_dig = r_bcd[d*C_DIGIT_W +: C_DIGIT_W];
            if (v_dig >= 4'd5) begin
                w_adj[d*C_DIGIT_W +: C_DIGIT_W] = v_dig + 4'd3;
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == C_CNT_W'(C_VALUE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: shift the binary word into the bcd digits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= w_mag;
            r_bcd <= '0;
            r_neg <= i_value[C_VALUE_W-1];
        end else if (r_busy) begin
            r_bcd <= {w_adj[C_BCD_W-2:0], r_bin[C_VALUE_W-1]};
            r_bin <= {r_bin[C_VALUE_W-2:0], 1'b0};
        end
    end

    assign o_busy       = r_busy;
    assign o_done       = r_done;
    assign o_result.neg = r_neg;
    assign o_result.bcd = r_bcd;

endmodule

// File: rtl/sitda_emit.sv
// ----------------------------------------------------------------------------
// sitda_emit
// Drops leading zeros and sends the sign and digits one character per item.
// ----------------------------------------------------------------------------
module sitda_emit
    import sitda_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  t_bcd_result         i_result,
    output logic                o_busy,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [C_CHAR_W-1:0] o_char_byte,
    output logic                o_last_char
);

    localparam int C_CNT_W = $clog2(C_NUM_DIGITS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SKIP  = 2'd1;
    localparam logic [1:0] S_SIGN  = 2'd2;
    localparam logic [1:0] S_DIGIT = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [C_BCD_W-1:0]   r_bcd, n_bcd;
    logic [C_CNT_W-1:0]   r_cnt, n_cnt;
    logic                 r_neg, n_neg;
    logic                 r_out_valid, n_out_valid;
    logic [C_CHAR_W-1:0]  r_char, n_char;
    logic                 r_last, n_last;
    logic                 w_out_free;
    logic [C_DIGIT_W-1:0] w_top;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_top      = r_bcd[C_BCD_W-1 -: C_DIGIT_W];

    // next state and output register load
    always_comb begin
        n_state     = r_state;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_load) begin
                    n_bcd   = i_result.bcd;
                    n_neg   = i_result.neg;
                    n_cnt   = C_CNT_W'(C_NUM_DIGITS);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // one leading zero a cycle, keep at least one digit
                if (w_top == '0 && r_cnt > C_CNT_W'(1)) begin
                    n_bcd = {r_bcd[C_BCD_W-C_DIGIT_W-1:0], {C_DIGIT_W{1'b0}}};
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    n_state = r_neg ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = C_CHAR_MINUS;
                    n_last      = 1'b0;
                    n_state     = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = C_CHAR_ZERO + {{(C_CHAR_W-C_DIGIT_W){1'b0}}, w_top};
                    n_last      = (r_cnt == C_CNT_W'(1));
                    n_bcd       = {r_bcd[C_BCD_W-C_DIGIT_W-1:0], {C_DIGIT_W{1'b0}}};
                    n_cnt       = r_cnt - 1'b1;
                    if (r_cnt == C_CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_char_byte = r_char;
    assign o_last_char = r_last;

endmodule

// File: rtl/signed_int_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Prints a signed 32-bit integer as decimal ascii text, one byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall / i_value) takes one signed integer.
//   Output channel (o_valid / i_stall / o_char_byte / o_last_char) gives its
//   text, most significant digit first, '-' ahead of negative values, no
//   leading zeros; o_last_char marks the final byte of each number.
//   An item is taken when valid is high and stall is low.
// Operation:
//   Shift and add-3 over the 32 input bits in the bcd engine (one input bit
//   a cycle), a handoff to the emitter, then up to 9 leading zeros dropped
//   (one digit a cycle), then one character sent per cycle (1 to 11 in all)
//   while the receiver does not stall.
//   One number is converted at a time; the next item is taken once the last
//   byte has been loaded into the output register.
// Reset and stall:
//   Reset clears the engine control and the output valid flag; no item is in
//   flight, and the input is stalled while reset is held.
//   A stalled output byte holds, and the emitter waits on it.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top
    import sitda_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [C_VALUE_W-1:0] i_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [C_CHAR_W-1:0]         o_char_byte,
    output logic                        o_last_char
);

    logic        w_start;
    logic        w_bcd_busy;
    logic        w_bcd_done;
    logic        w_emit_busy;
    t_bcd_result w_result;

    // take a new item only when both stages are free and out of reset
    assign o_stall = !i_rst_n || w_bcd_busy || w_bcd_done || w_emit_busy;
    assign w_start = i_valid && !o_stall;

    sitda_bcd u_bcd (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_value  (i_value),
        .o_busy   (w_bcd_busy),
        .o_done   (w_bcd_done),
        .o_result (w_result)
    );

    sitda_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_bcd_done),
        .i_result    (w_result),
        .o_busy      (w_emit_busy),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_byte (o_char_byte),
        .o_last_char (o_last_char)
    );

endmodule

// File: bench/tb_signed_int_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii_top
// Self-checking bench for the signed integer to decimal text converter.
// A directed table covers zero, single and multi digit values, both signs and
// both ends of the 32-bit range, then random numbers of every digit count run
// under several idle and stall mixes. Every output byte is compared with a
// queue of characters expected for each accepted number.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii_top
    import sitda_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int N_DIRECTED     = 20;

    // one expected output character
    typedef struct packed {
        logic [C_CHAR_W-1:0] char_byte;
        logic                last_char;
    } t_char_item;

    // directed row: an empty text means the expected text is predicted
    typedef struct {
        logic [C_VALUE_W-1:0] word;
        string                text;
    } t_dir_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic signed [C_VALUE_W-1:0] i_value;
    logic                        o_valid;
    logic                        i_stall;
    logic [C_CHAR_W-1:0]         o_char_byte;
    logic                        o_last_char;

    t_char_item expected_text[$];
    int         error_count  = 0;
    int         idle_pct     = 0;
    int         stall_pct    = 0;
    bit         hold_pending = 1'b0;
    int         quiet_cycles = 0;

    t_dir_row dir_rows [N_DIRECTED] = '{
        '{32'h0000_0000, "0"},
        '{32'h0000_0001, "1"},
        '{32'hFFFF_FFFF, "-1"},
        '{32'h0000_0009, "9"},
        '{32'h0000_000A, "10"},
        '{32'hFFFF_FFF6, "-10"},
        '{32'h0000_0064, "100"},
        '{32'h7FFF_FFFF, "2147483647"},
        '{32'h8000_0000, "-2147483648"},
        '{32'h8000_0001, "-2147483647"},
        '{32'h3B9A_CA00, "1000000000"},
        '{32'h3B9A_C9FF, "999999999"},
        '{32'hC465_3600, "-1000000000"},
        '{32'h5555_5555, ""},
        '{32'hAAAA_AAAA, ""},
        '{32'h0000_3039, ""},
        '{32'hFFF0_EDFA, ""},
        '{32'h0000_FFFF, ""},
        '{32'hFFFF_0000, ""},
        '{32'h0010_0000, ""}
    };

    signed_int_to_decimal_ascii_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_byte (o_char_byte),
        .o_last_char (o_last_char)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // queue the decimal text of one number, sign first, msd first
    function automatic void predict_decimal_text(input logic [C_VALUE_W-1:0] word);
        logic [C_VALUE_W-1:0] magnitude;
        logic [3:0]           digit_buf [C_NUM_DIGITS];
        int                   n_digits;
        t_char_item           ch;
        magnitude = word[C_VALUE_W-1] ? (32'd0 - word) : word;
        n_digits  = 0;
        do begin
            digit_buf[n_digits] = 4'(magnitude % 10);
            magnitude = magnitude / 10;
            n_digits++;
        end while (magnitude != 0);
        if (word[C_VALUE_W-1]) begin
            ch.char_byte = C_CHAR_MINUS;
            ch.last_char = 1'b0;
            expected_text.push_back(ch);
        end
        for (int i = n_digits - 1; i >= 0; i--) begin
            ch.char_byte = C_CHAR_ZERO + C_CHAR_W'(digit_buf[i]);
            ch.last_char = (i == 0);
            expected_text.push_back(ch);
        end
    endfunction

    // random number: mostly a chosen digit count and sign, some raw words and range ends
    function automatic logic [C_VALUE_W-1:0] random_word();
        int unsigned pick;
        int unsigned n_digits;
        int unsigned lo;
        int unsigned hi;
        int unsigned magnitude;
        bit          neg;
        pick = $urandom_range(9);
        if (pick < 2) begin
            return $urandom();
        end
        if (pick == 2) begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        n_digits = $urandom_range(10, 1);
        neg      = 1'($urandom_range(1));
        lo       = 1;
        repeat (n_digits - 1) lo = lo * 10;
        if (n_digits == 1) begin
            lo = 0;
            hi = 9;
        end else if (n_digits == 10) begin
            hi = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            hi = lo * 10 - 1;
        end
        magnitude = $urandom_range(hi, lo);
        return neg ? (32'd0 - magnitude) : magnitude;
    endfunction

    // offer one item, holding it until taken; random gap ahead of it
    task automatic offer_item(input logic [C_VALUE_W-1:0] word, input string text);
        t_char_item ch;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_valid <= 1'b1;
        i_value <= word;
        do @(posedge i_clk); while (o_stall);
        if (text.len() == 0) begin
            predict_decimal_text(word);
        end else begin
            for (int i = 0; i < text.len(); i++) begin
                ch.char_byte = text[i];
                ch.last_char = (i == text.len() - 1);
                expected_text.push_back(ch);
            end
        end
    endtask

    task automatic run_random(input int n_items, input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (n_items) offer_item(random_word(), "");
    endtask

    task automatic wait_for_text_drained();
        i_valid <= 1'b0;
        while (expected_text.size() != 0) @(posedge i_clk);
    endtask

    // receiver: random stall, or a long hold-off on request
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
        end
    end

    // output check against the oldest expected character
    always @(posedge i_clk) begin
        t_char_item exp_ch;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_text.size() == 0) begin
                $error("unexpected char_byte 0x%02h last_char %0b", o_char_byte, o_last_char);
                error_count++;
            end else begin
                exp_ch = expected_text.pop_front();
                if (o_char_byte !== exp_ch.char_byte) begin
                    $error("char_byte: expected 0x%02h, got 0x%02h",
                           exp_ch.char_byte, o_char_byte);
                    error_count++;
                end
                if (o_last_char !== exp_ch.last_char) begin
                    $error("last_char: expected %0b, got %0b",
                           exp_ch.last_char, o_last_char);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_signed_int_to_decimal_ascii_top: FAIL");
            $finish;
        end
    end

    // stimulus
    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_value = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, no idling
        foreach (dir_rows[i]) offer_item(dir_rows[i].word, dir_rows[i].text);
        wait_for_text_drained();

        run_random(80, 0, 0);
        run_random(70, 75, 0);
        run_random(70, 0, 75);
        run_random(70, 36, 36);

        // long receiver hold-off while items keep coming
        idle_pct     = 0;
        stall_pct    = 0;
        hold_pending = 1'b1;
        repeat (20) offer_item(random_word(), "");

        // sender waits for every byte before going on
        wait_for_text_drained();
        run_random(30, 36, 36);

        wait_for_text_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_signed_int_to_decimal_ascii_top: PASS");
        end else begin
            $display("tb_signed_int_to_decimal_ascii_top: FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/sitda_pkg.sv
rtl/sitda_bcd.sv
rtl/sitda_emit.sv
rtl/signed_int_to_decimal_ascii_top.sv
bench/tb_signed_int_to_decimal_ascii_top.sv
